// ----- rtl/bslt_pkg.sv -----
// bslt_pkg: shared types and constants of the bracket scope line tokenizer
// no dependencies; used by the channel interfaces, the core and the top level
`default_nettype none

package bslt_pkg;

	localparam int CHAR_W        = 8;
	localparam int SCOPE_W       = 8;
	localparam int MAX_DEPTH_DEF = 255;

	localparam logic [CHAR_W-1:0]  CH_OPEN   = 8'h5B;
	localparam logic [CHAR_W-1:0]  CH_CLOSE  = 8'h5D;
	localparam logic [CHAR_W-1:0]  CH_BAR    = 8'h7C;
	localparam logic [CHAR_W-1:0]  CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0]  CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0]  CH_CR     = 8'h0D;
	localparam logic [SCOPE_W-1:0] SCOPE_MAX = 8'hFF;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_LINE = 1'b1;

	typedef struct packed {
		logic               valid;
		logic               kind;
		logic [CHAR_W-1:0]  char_out;
		logic               line_fail;
		logic               line_packed;
		logic [SCOPE_W-1:0] line_scope;
	} tok_res_t;

endpackage

`default_nettype wire

// ----- rtl/bslt_if.sv -----
// bslt_char_if, bslt_tok_if: valid/ready channels for input characters and tokens
// depends on bslt_pkg for field widths
`default_nettype none

interface bslt_char_if;
	import bslt_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface bslt_tok_if;
	import bslt_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [CHAR_W-1:0]  char_out;
	logic               line_fail;
	logic               line_packed;
	logic [SCOPE_W-1:0] line_scope;

	modport source (output valid, output kind, output char_out, output line_fail,
		output line_packed, output line_scope, input ready);
	modport sink (input valid, input kind, input char_out, input line_fail,
		input line_packed, input line_scope, output ready);
endinterface

`default_nettype wire

// ----- rtl/bslt_core.sv -----
// bslt_core: bracket nesting mode machine, depth/peak counters and line flags
// depends on bslt_pkg; result is combinational from the character, state commits on step
`default_nettype none

module bslt_core #(
	parameter int MAX_DEPTH = bslt_pkg::MAX_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [bslt_pkg::CHAR_W-1:0] ch,
	input  wire logic                        step,
	output bslt_pkg::tok_res_t               res
);
	import bslt_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1) + 1;
	localparam int PW = DW - 1;
	localparam int CW = (PW > SCOPE_W) ? PW : SCOPE_W;

	localparam logic signed [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);
	localparam logic signed [DW-1:0] DEPTH_MIN = -DEPTH_MAX;
	localparam logic signed [DW-1:0] DEPTH_ONE = DW'(1);
	localparam logic signed [DW-1:0] DEPTH_ZERO = '0;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_OPENING,
		MODE_READING,
		MODE_CLOSING
	} mode_t;

	mode_t                  mode_q, nxt_mode;
	logic signed [DW-1:0]   depth_q, nxt_depth, up_depth, dn_depth;
	logic [PW-1:0]          peak_q, nxt_peak, up_peak;
	logic                   fail_q, nxt_fail, packed_q, nxt_packed;
	logic                   fail_v, emit_c, emit_l, blank, dn_zero;
	logic [CW-1:0]          peak_w;
	logic [SCOPE_W-1:0]     scope;

	assign blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));

	assign up_depth = (depth_q < DEPTH_MAX) ? depth_q + DEPTH_ONE : depth_q;
	assign up_peak  = (up_depth > $signed({1'b0, peak_q})) ? up_depth[PW-1:0] : peak_q;
	assign dn_depth = (depth_q > DEPTH_MIN) ? depth_q - DEPTH_ONE : depth_q;
	assign dn_zero  = (dn_depth == DEPTH_ZERO);

	assign peak_w = CW'(peak_q);
	assign scope  = (peak_w > CW'(SCOPE_MAX)) ? SCOPE_MAX : peak_w[SCOPE_W-1:0];

	always_comb begin
		nxt_mode   = mode_q;
		nxt_depth  = depth_q;
		nxt_peak   = peak_q;
		fail_v     = fail_q;
		nxt_packed = packed_q;
		emit_c     = 1'b0;
		emit_l     = 1'b0;
		if (!blank) begin
			if (ch == CH_BAR) begin
				nxt_packed = 1'b1;
			end
			case (mode_q)
				MODE_IDLE: begin
					if (ch == CH_OPEN) begin
						nxt_mode  = MODE_OPENING;
						nxt_depth = up_depth;
						nxt_peak  = up_peak;
					end
				end
				MODE_OPENING: begin
					if (ch == CH_OPEN) begin
						nxt_depth = up_depth;
						nxt_peak  = up_peak;
					end else if (ch == CH_CLOSE) begin
						nxt_mode = MODE_CLOSING;
					end else begin
						nxt_mode = MODE_READING;
						emit_c   = 1'b1;
					end
				end
				MODE_READING: begin
					if (ch == CH_OPEN) begin
						fail_v   = 1'b1;
						nxt_mode = MODE_IDLE;
						emit_l   = 1'b1;
					end else if (ch == CH_CLOSE) begin
						nxt_depth = dn_depth;
						nxt_mode  = dn_zero ? MODE_IDLE : MODE_CLOSING;
						emit_l    = dn_zero;
					end else begin
						emit_c = 1'b1;
					end
				end
				default: begin
					if (ch == CH_OPEN) begin
						fail_v   = fail_q || (depth_q != DEPTH_ZERO);
						nxt_mode = MODE_OPENING;
						emit_l   = 1'b1;
					end else if (ch == CH_CLOSE) begin
						nxt_depth = dn_depth;
						if (dn_zero) begin
							nxt_mode = MODE_IDLE;
							emit_l   = 1'b1;
						end
					end else begin
						fail_v   = fail_q || (depth_q != DEPTH_ZERO);
						nxt_mode = MODE_IDLE;
						emit_l   = 1'b1;
					end
				end
			endcase
		end
		nxt_fail = fail_v;
		res.valid       = emit_c || emit_l;
		res.kind        = emit_l ? KIND_LINE : KIND_CHAR;
		res.char_out    = emit_c ? ch : '0;
		res.line_fail   = emit_l && fail_v;
		res.line_packed = emit_l && nxt_packed;
		res.line_scope  = emit_l ? scope : '0;
		if (emit_l) begin
			nxt_depth  = '0;
			nxt_peak   = '0;
			nxt_fail   = 1'b0;
			nxt_packed = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			depth_q  <= '0;
			peak_q   <= '0;
			fail_q   <= 1'b0;
			packed_q <= 1'b0;
		end else if (step) begin
			mode_q   <= nxt_mode;
			depth_q  <= nxt_depth;
			peak_q   <= nxt_peak;
			fail_q   <= nxt_fail;
			packed_q <= nxt_packed;
		end
	end

	a_depth_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q <= DEPTH_MAX) && (depth_q >= DEPTH_MIN))
		else $error("nesting depth out of saturation bounds");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (depth_q == DEPTH_ZERO) && (peak_q == '0) && !fail_q)
		else $error("idle mode with live line state");

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.valid && (res.kind == KIND_LINE))
		|=> (depth_q == DEPTH_ZERO) && (peak_q == '0) && !fail_q && !packed_q)
		else $error("line end did not clear line state");

	a_char_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.kind == KIND_CHAR))
		|-> ((mode_q == MODE_OPENING) || (mode_q == MODE_READING)))
		else $error("content beat outside opening or reading mode");

endmodule

`default_nettype wire

// ----- rtl/bracket_scope_line_tokenizer_top.sv -----
// bracket_scope_line_tokenizer_top: character input register, core, token output register
// depends on bslt_pkg, bslt_char_if, bslt_tok_if and bslt_core
//
// usage:
//   char_ch carries one character byte per beat; tok_ch carries token beats,
//   either a content character (kind 0) or a line end (kind 1) with the line's
//   fail flag, packed flag and greatest bracket depth
//   whitespace and bracket characters that do not end a line give no token beat
//   a character beat is taken into the input register, and its token is
//   registered into the output register, which drives tok_ch, once it is free
//   throughput: one character per cycle while no stall holds the input
//   register; the mode and depth update is a single pass of logic between
//   the input register and the output register; a stall on tok_ch holds
//   the token in the output register; the input register keeps taking
//   beats while the next character produces no token, and char_ch.ready
//   drops only once a token-producing character waits behind a stalled token
//   reset empties both registers, returns the mode machine to idle and zeroes
//   depth, peak and flags; a line left open at end of input never gets a
//   line-end token
`default_nettype none

module bracket_scope_line_tokenizer_top #(
	parameter int MAX_DEPTH = bslt_pkg::MAX_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bslt_char_if.sink  char_ch,
	bslt_tok_if.source tok_ch
);
	import bslt_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] ch_s1;
	logic              valid_s2;
	tok_res_t          res, res_s2;
	logic              out_free, advance;

	assign out_free      = !valid_s2 || tok_ch.ready;
	assign advance       = valid_s1 && (!res.valid || out_free);
	assign char_ch.ready = !valid_s1 || advance;

	bslt_core #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.ch    (ch_s1),
		.step  (advance),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (char_ch.valid && char_ch.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance && res.valid) begin
				valid_s2 <= 1'b1;
			end else if (tok_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_ch.valid && char_ch.ready) begin
			ch_s1 <= char_ch.ch;
		end
		if (advance && res.valid) begin
			res_s2 <= res;
		end
	end

	assign tok_ch.valid       = valid_s2;
	assign tok_ch.kind        = res_s2.kind;
	assign tok_ch.char_out    = res_s2.char_out;
	assign tok_ch.line_fail   = res_s2.line_fail;
	assign tok_ch.line_packed = res_s2.line_packed;
	assign tok_ch.line_scope  = res_s2.line_scope;

endmodule

`default_nettype wire

// ----- dv/bracket_scope_line_tokenizer_top_tb.sv -----
// bracket_scope_line_tokenizer_top_tb: self-checking testbench, directed table then random text
// depends on bslt_pkg, bslt_char_if, bslt_tok_if and bracket_scope_line_tokenizer_top
// tokens are predicted per accepted character beat and compared in order on tok_ch
module bracket_scope_line_tokenizer_top_tb;
	import bslt_pkg::*;

	localparam int DEPTH_LIM    = MAX_DEPTH_DEF;
	localparam int DIR_ROWS     = 25;
	localparam int PHASE_ITEMS  = 145;
	localparam int DEEP_RUN     = 258;
	localparam int HOLD_CYCLES  = 60;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;

	typedef enum logic [1:0] {SC_IDLE, SC_OPENING, SC_READING, SC_CLOSING} scan_mode_e;
	typedef enum int {SH_WELL, SH_BROKEN, SH_NOISE, SH_DEEP_UP, SH_DEEP_DOWN} shape_e;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		bit                typed;
		tok_res_t          want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	bslt_char_if char_if();
	bslt_tok_if  tok_if();

	bracket_scope_line_tokenizer_top #(.MAX_DEPTH(DEPTH_LIM)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.char_ch(char_if),
		.tok_ch (tok_if)
	);

	// scanner state of the predictor
	scan_mode_e scan_mode;
	int         nest;
	int         peak;
	bit         fail_f;
	bit         bar_f;

	tok_res_t pending_tokens[$];
	int       mismatch_cnt;
	int       items_sent;
	int       gap_pct;
	int       stall_pct;
	bit       hold_req;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{8'h00,    1'b1, '0},
		'{CH_SPACE, 1'b1, '0},
		'{CH_OPEN,  1'b0, '0},
		'{CH_TAB,   1'b1, '0},
		'{8'h78,    1'b1, '{1'b1, KIND_CHAR, 8'h78, 1'b0, 1'b0, 8'd0}},
		'{CH_CLOSE, 1'b1, '{1'b1, KIND_LINE, 8'h00, 1'b0, 1'b0, 8'd1}},
		'{CH_OPEN,  1'b0, '0},
		'{CH_OPEN,  1'b0, '0},
		'{CH_BAR,   1'b1, '{1'b1, KIND_CHAR, CH_BAR, 1'b0, 1'b0, 8'd0}},
		'{CH_CLOSE, 1'b0, '0},
		'{CH_CLOSE, 1'b1, '{1'b1, KIND_LINE, 8'h00, 1'b0, 1'b1, 8'd2}},
		'{CH_OPEN,  1'b0, '0},
		'{8'hFF,    1'b1, '{1'b1, KIND_CHAR, 8'hFF, 1'b0, 1'b0, 8'd0}},
		'{CH_OPEN,  1'b1, '{1'b1, KIND_LINE, 8'h00, 1'b1, 1'b0, 8'd1}},
		'{CH_OPEN,  1'b0, '0},
		'{CH_OPEN,  1'b0, '0},
		'{8'h61,    1'b0, '0},
		'{CH_CLOSE, 1'b0, '0},
		'{CH_OPEN,  1'b0, '0},
		'{CH_CLOSE, 1'b0, '0},
		'{8'h62,    1'b0, '0},
		'{CH_OPEN,  1'b0, '0},
		'{CH_CLOSE, 1'b0, '0},
		'{8'h0B,    1'b1, '0},
		'{CH_CLOSE, 1'b1, '{1'b1, KIND_LINE, 8'h00, 1'b0, 1'b0, 8'd1}}
	};

	always #6 clk = ~clk;

	function automatic void depth_up();
		if (nest < DEPTH_LIM)
			nest++;
		if (nest > peak)
			peak = nest;
	endfunction

	function automatic void depth_down();
		if (nest > -DEPTH_LIM)
			nest--;
	endfunction

	function automatic tok_res_t close_line();
		tok_res_t t;
		t = '0;
		t.valid       = 1'b1;
		t.kind        = KIND_LINE;
		t.line_fail   = fail_f;
		t.line_packed = bar_f;
		t.line_scope  = (peak > 255) ? SCOPE_MAX : SCOPE_W'(peak);
		nest   = 0;
		peak   = 0;
		fail_f = 1'b0;
		bar_f  = 1'b0;
		return t;
	endfunction

	function automatic tok_res_t scan_char(input logic [CHAR_W-1:0] c);
		tok_res_t t;
		t = '0;
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
			return t;
		if (c == CH_BAR)
			bar_f = 1'b1;
		case (scan_mode)
			SC_IDLE: begin
				if (c == CH_OPEN) begin
					scan_mode = SC_OPENING;
					depth_up();
				end
			end
			SC_OPENING: begin
				if (c == CH_OPEN) begin
					depth_up();
				end else if (c == CH_CLOSE) begin
					scan_mode = SC_CLOSING;
				end else begin
					scan_mode  = SC_READING;
					t.valid    = 1'b1;
					t.kind     = KIND_CHAR;
					t.char_out = c;
				end
			end
			SC_READING: begin
				if (c == CH_OPEN) begin
					fail_f    = 1'b1;
					scan_mode = SC_IDLE;
					t         = close_line();
				end else if (c == CH_CLOSE) begin
					scan_mode = SC_CLOSING;
					depth_down();
					if (nest == 0) begin
						scan_mode = SC_IDLE;
						t         = close_line();
					end
				end else begin
					t.valid    = 1'b1;
					t.kind     = KIND_CHAR;
					t.char_out = c;
				end
			end
			default: begin
				if (c == CH_OPEN) begin
					if (nest != 0)
						fail_f = 1'b1;
					scan_mode = SC_OPENING;
					t         = close_line();
				end else if (c == CH_CLOSE) begin
					depth_down();
					if (nest == 0) begin
						scan_mode = SC_IDLE;
						t         = close_line();
					end
				end else begin
					if (nest != 0)
						fail_f = 1'b1;
					scan_mode = SC_IDLE;
					t         = close_line();
				end
			end
		endcase
		return t;
	endfunction

	function automatic logic [CHAR_W-1:0] pick_blank();
		if ($urandom_range(5) == 0)
			return CH_SPACE;
		return CH_TAB + CHAR_W'($urandom_range(4));
	endfunction

	function automatic logic [CHAR_W-1:0] pick_content();
		logic [CHAR_W-1:0] c;
		if ($urandom_range(6) == 0)
			return CH_BAR;
		do begin
			c = CHAR_W'($urandom_range(255));
		end while (c == CH_OPEN || c == CH_CLOSE || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// one character beat; called and returns at a rising edge
	task automatic send_char(input logic [CHAR_W-1:0] c, input bit typed = 1'b0,
		input tok_res_t want = '0);
		tok_res_t pred;
		bit       took;
		while ($urandom_range(99) < gap_pct) begin
			char_if.valid <= 1'b0;
			@(posedge clk);
		end
		char_if.valid <= 1'b1;
		char_if.ch    <= c;
		do begin
			@(negedge clk);
			took = char_if.ready;
			@(posedge clk);
		end while (!took);
		items_sent++;
		pred = scan_char(c);
		if (typed)
			pred = want;
		if (pred.valid)
			pending_tokens.insert(pending_tokens.size(), pred);
	endtask

	task automatic send_shape(input shape_e shape);
		int n;
		int k;
		case (shape)
			SH_WELL: begin
				k = $urandom_range(1, 4);
				n = $urandom_range(1, 6);
				repeat (k) send_char(CH_OPEN);
				repeat (n) begin
					if ($urandom_range(9) == 0)
						send_char(pick_blank());
					send_char(pick_content());
				end
				repeat (k) send_char(CH_CLOSE);
			end
			SH_BROKEN: begin
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(5))
						0, 1: send_char(CH_OPEN);
						2, 3: send_char(CH_CLOSE);
						4: send_char($urandom_range(1) ? CH_BAR : pick_blank());
						default: send_char(pick_content());
					endcase
				end
			end
			SH_NOISE: begin
				repeat ($urandom_range(1, 8)) send_char(CHAR_W'($urandom_range(255)));
			end
			SH_DEEP_UP: begin
				// past the depth limit, then a bad open to report the peak
				repeat (DEEP_RUN) send_char(CH_OPEN);
				send_char(pick_content());
				send_char(CH_OPEN);
			end
			default: begin
				// restart at zero depth and fall to the negative limit
				send_char(CH_OPEN);
				send_char(CH_OPEN);
				send_char(pick_content());
				send_char(CH_CLOSE);
				send_char(CH_OPEN);
				send_char(CH_CLOSE);
				repeat (DEEP_RUN) send_char(CH_CLOSE);
				send_char(pick_content());
			end
		endcase
	endtask

	initial begin : tok_sink
		tok_res_t got;
		tok_res_t want;
		bit       take;
		int       hold_left;
		hold_left = 0;
		tok_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			take = arst_n && tok_if.valid && tok_if.ready;
			got  = '{1'b1, tok_if.kind, tok_if.char_out, tok_if.line_fail, tok_if.line_packed,
				tok_if.line_scope};
			@(posedge clk);
			if (take) begin
				if (pending_tokens.size() == 0) begin
					report_mismatch($sformatf("unexpected token kind %0b char %0h", got.kind,
						got.char_out));
				end else begin
					want = pending_tokens.pop_front();
					check_field("kind", got.kind, want.kind);
					check_field("char_out", got.char_out, want.char_out);
					check_field("line_fail", got.line_fail, want.line_fail);
					check_field("line_packed", got.line_packed, want.line_packed);
					check_field("line_scope", got.line_scope, want.line_scope);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				tok_if.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				tok_if.ready <= 1'b0;
			end else begin
				tok_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(negedge clk);
			if ((char_if.valid && char_if.ready) || (tok_if.valid && tok_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin : stim
		int gap_tab [4];
		int stall_tab [4];
		int base;
		int r;
		gap_tab   = '{0, 66, 0, 6};
		stall_tab = '{0, 0, 66, 6};
		clk           = 1'b0;
		arst_n        = 1'b0;
		char_if.valid = 1'b0;
		char_if.ch    = '0;
		scan_mode     = SC_IDLE;
		nest          = 0;
		peak          = 0;
		fail_f        = 1'b0;
		bar_f         = 1'b0;
		mismatch_cnt  = 0;
		items_sent    = 0;
		gap_pct       = 0;
		stall_pct     = 0;
		hold_req      = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_char(dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = gap_tab[ph];
			stall_pct = stall_tab[ph];
			if (ph == 0)
				send_shape(SH_DEEP_UP);
			// long receiver hold while content keeps coming
			if (ph == 0)
				hold_req = 1'b1;
			if (ph == 2)
				send_shape(SH_DEEP_DOWN);
			base = items_sent;
			while (items_sent - base < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 55)
					send_shape(SH_WELL);
				else if (r < 85)
					send_shape(SH_BROKEN);
				else
					send_shape(SH_NOISE);
			end
		end
		char_if.valid <= 1'b0;

		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
